FILE: rtl/iicv_pkg.sv
`default_nettype none

package iicv_pkg;

    // ASCII characters used by the format checks.
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_7     = 8'h37;
    localparam logic [7:0] CH_8     = 8'h38;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_X     = 8'h58;

    // Character positions within a code.
    localparam logic [4:0] POS_KIND        = 5'd2;
    localparam logic [4:0] POS_MAX         = 5'd31;
    localparam logic [4:0] ISSN_HEAD_END   = 5'd5;
    localparam logic [4:0] ISSN_DASH_POS   = 5'd9;
    localparam logic [4:0] ISSN_DIGIT_END  = 5'd12;
    localparam logic [4:0] ISSN_LAST_POS   = 5'd13;
    localparam logic [4:0] ISSN_WEIGHT_TOP = 5'd13;
    localparam logic [4:0] ISBN_HEAD_END   = 5'd6;
    localparam logic [4:0] ISBN_PREFIX_POS = 5'd7;
    localparam logic [4:0] ISBN_DASH_POS   = 5'd8;
    localparam logic [4:0] ISBN_LAST_POS   = 5'd21;

    // ISBN group limits.
    localparam logic [3:0] FIRST_GROUP_DIGITS = 4'd5;
    localparam logic [3:0] SUM_DIGITS         = 4'd9;
    localparam logic [3:0] ISBN_DIGITS        = 4'd10;
    localparam logic [3:0] COUNT_MAX          = 4'd15;
    localparam logic [2:0] LAST_GROUP         = 3'd3;
    localparam logic [2:0] GROUP_MAX          = 3'd4;

    // EAN-13 sums of the prefix 978 and 979, already reduced mod 10.
    localparam logic [3:0] SUM_PREFIX_978 = 4'd8;
    localparam logic [3:0] SUM_PREFIX_979 = 4'd9;

    typedef enum logic [1:0] {
        KIND_ISSN = 2'd0,
        KIND_ISBN = 2'd1,
        KIND_NONE = 2'd2
    } kind_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } iicv_beat_t;

    typedef struct packed {
        logic       valid_res;
        kind_t      kind;
    } iicv_verdict_t;

    typedef struct packed {
        logic [4:0]  position;
        kind_t       code_kind;
        logic        format_error;
        logic [3:0]  sum11;
        logic [3:0]  sum10;
        logic [3:0]  digit_count;
        logic [2:0]  group_index;
        logic [3:0]  group_length;
        logic [16:0] first_group;
    } iicv_state_t;

    localparam iicv_state_t STATE_RESET = '{
        position:     5'd0,
        code_kind:    KIND_NONE,
        format_error: 1'b0,
        sum11:        4'd0,
        sum10:        4'd0,
        digit_count:  4'd0,
        group_index:  3'd0,
        group_length: 4'd0,
        first_group:  17'd0
    };

    // Reduces a value below 88 mod 11 by restoring subtraction.
    function automatic logic [3:0] mod11(input logic [6:0] v);
        logic [6:0] t;
        begin
            t = v;
            if (t >= 7'd44)
            begin
                t = t - 7'd44;
            end
            if (t >= 7'd22)
            begin
                t = t - 7'd22;
            end
            if (t >= 7'd11)
            begin
                t = t - 7'd11;
            end
            return t[3:0];
        end
    endfunction

    // Reduces a value below 40 mod 10.
    function automatic logic [3:0] mod10(input logic [5:0] v);
        logic [5:0] t;
        begin
            t = v;
            if (t >= 6'd20)
            begin
                t = t - 6'd20;
            end
            if (t >= 6'd10)
            begin
                t = t - 6'd10;
            end
            return t[3:0];
        end
    endfunction

    // Registration group ranges allowed for the first ISBN group.
    function automatic logic first_group_ok(input logic [16:0] v);
        begin
            return (v <= 17'd5) || (v == 17'd7) ||
                   (v >= 17'd80 && v <= 17'd94) ||
                   (v >= 17'd600 && v <= 17'd649) ||
                   (v >= 17'd950 && v <= 17'd989) ||
                   (v >= 17'd9900 && v <= 17'd9980) ||
                   (v >= 17'd99900 && v <= 17'd99999);
        end
    endfunction

    // Longest allowed length of the ISBN group being closed by a separator.
    function automatic logic [3:0] group_limit(input logic [2:0] gi);
        begin
            case (gi)
                3'd0:    return 4'd5;
                3'd1:    return 4'd7;
                3'd2:    return 4'd6;
                default: return 4'd0;
            endcase
        end
    endfunction

    function automatic logic [7:0] issn_head(input logic [4:0] p);
        begin
            case (p)
                5'd0:    return CH_I;
                5'd1:    return CH_S;
                5'd2:    return CH_S;
                5'd3:    return CH_N;
                default: return CH_SPACE;
            endcase
        end
    endfunction

    function automatic logic [7:0] isbn_head(input logic [4:0] p);
        begin
            case (p)
                5'd0:    return CH_I;
                5'd1:    return CH_S;
                5'd2:    return CH_B;
                5'd3:    return CH_N;
                5'd4:    return CH_SPACE;
                5'd5:    return CH_9;
                default: return CH_7;
            endcase
        end
    endfunction

endpackage

`default_nettype wire

FILE: rtl/iicv_in_stage.sv
`default_nettype none

module iicv_in_stage
    import iicv_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,
    input  wire logic       s_tlast,
    input  wire logic       advance,
    output logic            beat_vld,
    output iicv_beat_t      beat
);

    logic       vld_reg;
    logic       vld_next;
    iicv_beat_t beat_reg;
    logic       take;

    // The held beat leaves whenever the step logic consumes it.
    assign s_tready = !vld_reg || advance;
    assign take     = s_tvalid && s_tready;

    always_comb
    begin
        vld_next = vld_reg;
        if (take)
        begin
            vld_next = 1'b1;
        end
        else if (advance)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            beat_reg <= '{ch: s_tdata, last: s_tlast};
        end
    end

    assign beat_vld = vld_reg;
    assign beat     = beat_reg;

endmodule

`default_nettype wire

FILE: rtl/iicv_step.sv
`default_nettype none

module iicv_step
    import iicv_pkg::*;
(
    input  wire iicv_beat_t  beat,
    input  wire iicv_state_t cur,
    output iicv_state_t      nxt,
    output iicv_verdict_t    verdict
);

    logic [4:0]  p;
    logic        is_digit;
    logic [3:0]  d;
    logic [3:0]  w;
    logic [7:0]  prod11;
    logic [6:0]  acc11;
    logic [5:0]  mul10;
    logic [5:0]  acc10;
    logic [19:0] fg_x10;
    logic [7:0]  want11;
    logic [3:0]  want10;
    logic        issn_ok;
    logic        isbn_ok;
    iicv_state_t upd;

    assign p        = cur.position;
    assign is_digit = (beat.ch >= CH_0) && (beat.ch <= CH_9);
    assign d        = beat.ch[3:0];

    // ISSN weights run 8..5 before the dash and 4..2 after it.
    assign w      = (p < ISSN_DASH_POS) ? 4'(ISSN_WEIGHT_TOP - p)
                                        : 4'(ISSN_WEIGHT_TOP + 5'd1 - p);
    assign prod11 = {4'b0, d} * {4'b0, w};
    assign acc11  = prod11[6:0] + {3'b0, cur.sum11};

    // EAN-13 weights alternate 3 and 1 after the prefix.
    assign mul10  = cur.digit_count[0] ? {2'b0, d} : ({1'b0, d, 1'b0} + {2'b0, d});
    assign acc10  = mul10 + {2'b0, cur.sum10};

    assign fg_x10 = {cur.first_group, 3'b0} + {2'b0, cur.first_group, 1'b0} + {16'b0, d};

    always_comb
    begin
        upd = cur;
        if (p < POS_KIND)
        begin
            if (beat.ch != issn_head(p))
            begin
                upd.format_error = 1'b1;
            end
        end
        else if (p == POS_KIND)
        begin
            if (beat.ch == CH_S)
            begin
                upd.code_kind = KIND_ISSN;
            end
            else if (beat.ch == CH_B)
            begin
                upd.code_kind = KIND_ISBN;
            end
            else
            begin
                upd.code_kind = KIND_NONE;
            end
        end

        if (p >= POS_KIND)
        begin
            case (upd.code_kind)
                KIND_ISSN:
                begin
                    if (p < ISSN_HEAD_END)
                    begin
                        if (beat.ch != issn_head(p))
                        begin
                            upd.format_error = 1'b1;
                        end
                    end
                    else if (p == ISSN_DASH_POS)
                    begin
                        if (beat.ch != CH_DASH)
                        begin
                            upd.format_error = 1'b1;
                        end
                    end
                    else if (p <= ISSN_DIGIT_END)
                    begin
                        if (!is_digit)
                        begin
                            upd.format_error = 1'b1;
                        end
                        else
                        begin
                            upd.sum11 = mod11(acc11);
                        end
                    end
                end
                KIND_ISBN:
                begin
                    if (p <= ISBN_HEAD_END)
                    begin
                        if (beat.ch != isbn_head(p))
                        begin
                            upd.format_error = 1'b1;
                        end
                    end
                    else if (p == ISBN_PREFIX_POS)
                    begin
                        if (beat.ch == CH_8)
                        begin
                            upd.sum10 = SUM_PREFIX_978;
                        end
                        else if (beat.ch == CH_9)
                        begin
                            upd.sum10 = SUM_PREFIX_979;
                        end
                        else
                        begin
                            upd.format_error = 1'b1;
                        end
                    end
                    else if (p == ISBN_DASH_POS)
                    begin
                        if (beat.ch != CH_DASH)
                        begin
                            upd.format_error = 1'b1;
                        end
                    end
                    else if (p <= ISBN_LAST_POS)
                    begin
                        if (is_digit)
                        begin
                            if (cur.group_index == 3'd0 &&
                                cur.group_length < FIRST_GROUP_DIGITS)
                            begin
                                upd.first_group = fg_x10[16:0];
                            end
                            if (cur.digit_count < SUM_DIGITS)
                            begin
                                upd.sum10 = mod10(acc10);
                            end
                            if (cur.group_length < COUNT_MAX)
                            begin
                                upd.group_length = cur.group_length + 4'd1;
                            end
                            if (cur.digit_count < COUNT_MAX)
                            begin
                                upd.digit_count = cur.digit_count + 4'd1;
                            end
                        end
                        else
                        begin
                            // A separator closes the current group.
                            if (cur.group_length == 4'd0 ||
                                cur.group_length > group_limit(cur.group_index))
                            begin
                                upd.format_error = 1'b1;
                            end
                            if (cur.group_index == 3'd0 && !first_group_ok(cur.first_group))
                            begin
                                upd.format_error = 1'b1;
                            end
                            if (cur.group_index < GROUP_MAX)
                            begin
                                upd.group_index = cur.group_index + 3'd1;
                            end
                            upd.group_length = 4'd0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        if (upd.sum11 == 4'd0)
        begin
            want11 = CH_0;
        end
        else if (upd.sum11 == 4'd1)
        begin
            want11 = CH_X;
        end
        else
        begin
            want11 = CH_0 + {4'b0, 4'd11 - upd.sum11};
        end
    end

    assign want10 = (upd.sum10 == 4'd0) ? 4'd0 : (4'd10 - upd.sum10);

    assign issn_ok = (upd.code_kind == KIND_ISSN) && (p == ISSN_LAST_POS) &&
                     !upd.format_error && (beat.ch == want11);
    assign isbn_ok = (upd.code_kind == KIND_ISBN) && (p == ISBN_LAST_POS) &&
                     !upd.format_error && (upd.group_index == LAST_GROUP) &&
                     (upd.group_length == 4'd1) && (upd.digit_count == ISBN_DIGITS) &&
                     is_digit && (d == want10);

    assign verdict = '{valid_res: issn_ok || isbn_ok, kind: upd.code_kind};

    always_comb
    begin
        if (beat.last)
        begin
            nxt = STATE_RESET;
        end
        else
        begin
            nxt = upd;
            if (cur.position < POS_MAX)
            begin
                nxt.position = cur.position + 5'd1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/iicv_out_stage.sv
`default_nettype none

module iicv_out_stage
    import iicv_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          load,
    input  wire iicv_verdict_t verdict,
    output logic               slot_free,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [7:0]         m_tdata
);

    logic          vld_reg;
    logic          vld_next;
    iicv_verdict_t verdict_reg;

    assign slot_free = !vld_reg || m_tready;

    always_comb
    begin
        vld_next = vld_reg;
        if (load)
        begin
            vld_next = 1'b1;
        end
        else if (m_tready)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            verdict_reg <= verdict;
        end
    end

    assign m_tvalid = vld_reg;
    assign m_tdata  = {5'b0, verdict_reg.kind, verdict_reg.valid_res};

endmodule

`default_nettype wire

FILE: rtl/issn_isbn_code_validator.sv
// Path: an accepted character beat is held in the input register; a last beat's
// verdict is loaded from there into the result register, which drives m_tvalid.
// Throughput: one character beat per cycle; the result register and the input register
// decouple the two sides, so only a held result that is not taken can stall a last beat.
// Reset (rst_n low, asynchronous) empties both registers and returns the parse state to
// position zero with no kind picked; the block is ready as soon as reset is released.
`default_nettype none

module issn_isbn_code_validator
    import iicv_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    // Input stream: one ASCII character of the code per beat.
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] ch
    input  wire logic       s_tlast,   // marks the final character of the code
    // Result stream: one beat per code.
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata    // [0] valid_res, [2:1] kind, [7:3] zero
);

    logic          beat_vld;
    iicv_beat_t    beat;
    logic          advance;
    logic          slot_free;
    iicv_state_t   state_reg;
    iicv_state_t   state_next;
    iicv_verdict_t verdict;

    // The held beat moves on every cycle unless it is the last character of a code
    // and the result register is still occupied by an untaken verdict.
    assign advance = beat_vld && (!beat.last || slot_free);

    iicv_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .advance  (advance),
        .beat_vld (beat_vld),
        .beat     (beat)
    );

    // The whole per-character update (format checks, running mod 11 and mod 10 sums,
    // ISBN group tracking) and the verdict for a last character are computed here.
    iicv_step u_step (
        .beat    (beat),
        .cur     (state_reg),
        .nxt     (state_next),
        .verdict (verdict)
    );

    // Parse state for the code in progress; it returns to reset after each last beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    iicv_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && beat.last),
        .verdict   (verdict),
        .slot_free (slot_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

FILE: rtl/iicv_checker.sv
`default_nettype none

module iicv_checker
    import iicv_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic [7:0] s_tdata,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata
);

    // A stalled result beat keeps its value.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // Kind code three is never produced and the pad bits stay zero.
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[2:1] != 2'd3 && m_tdata[7:3] == 5'd0)
        else $error("bad kind code or pad bits in result beat");

    // A code of neither kind is never reported valid.
    a_none: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> m_tdata[2:1] != KIND_NONE)
        else $error("valid verdict for a code of unknown kind");

    // With no result waiting, nothing can hold the input side back.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with an empty result register");

    // An offered character beat is only held off while a result is waiting.
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |-> m_tvalid)
        else $error("input stalled without a pending result");

    // The character itself is not checked here; an offered beat must simply carry a known value.
    a_data_known: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid |-> !$isunknown(s_tdata))
        else $error("unknown character on an offered beat");

endmodule

bind issn_isbn_code_validator iicv_checker u_iicv_checker (.*);

`default_nettype wire

FILE: test/tb_issn_isbn_code_validator.sv
module tb_issn_isbn_code_validator;
    import iicv_pkg::*;

    // The run is stopped by force if it takes longer than this many cycles.
    localparam int CYCLE_LIMIT = 400000;

    // Length of the receiver hold-off in the pressure phase, in cycles.
    localparam int HOLD_CYCLES = 300;

    typedef logic [7:0] char_t;

    // Idling regimes.
    // In the pressure phase the receiver holds off once for a long stretch.
    typedef enum int {
        PH_STEADY,
        PH_SRC_IDLE,
        PH_SNK_STALL,
        PH_BOTH,
        PH_PRESSURE
    } phase_t;

    // One character beat as offered to the block. A directed row may carry a
    // verdict typed in by hand, which then replaces the predicted one.
    typedef struct {
        char_t         ch;
        logic          last;
        logic          pinned;
        iicv_verdict_t pin;
    } char_beat_t;

    typedef struct {
        string text;
        bit    pinned;
        logic  want_valid;
        kind_t want_kind;
    } code_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;   // [7:0] ch
    logic       s_tlast = 1'b0;    // marks the final character of the code
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;           // [0] valid_res, [2:1] kind, [7:3] zero

    phase_t phase = PH_STEADY;

    // Beats offered but not yet taken, and verdicts that are still owed.
    char_beat_t    offered_beats[$];
    iicv_verdict_t verdicts_due[$];

    int beats_accepted = 0;
    int errors = 0;
    int cycle_count = 0;

    // Text of the code being built by the stimulus generators.
    char_t code_text[$];

    // Parse state of the predictor. It mirrors what the block must track
    // between characters and is cleared after every last beat.
    logic [4:0]  at_pos;
    kind_t       picked_kind;
    logic        bad_format;
    logic [3:0]  issn_sum;
    logic [3:0]  ean_sum;
    logic [3:0]  isbn_digits;
    logic [2:0]  group_no;
    logic [3:0]  group_len;
    logic [16:0] group_one_value;

    issn_isbn_code_validator uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // The directed codes. A verdict is typed in only where it is plain from
    // the text: codes that are too short, codes of the wrong length, a
    // broken head, and characters that can never be digits. Every other row
    // is checked against the predictor.
    code_row_t directed_codes[] = '{
        '{"I",                      1'b1, 1'b0, KIND_NONE},
        '{"IS",                     1'b1, 1'b0, KIND_NONE},
        '{"ISQ",                    1'b1, 1'b0, KIND_NONE},
        '{"IS\377N 0378-5955",      1'b1, 1'b0, KIND_NONE},
        '{"ISB",                    1'b1, 1'b0, KIND_ISBN},
        '{"ISSN 0378-5955",         1'b0, 1'b0, KIND_NONE},
        '{"ISSN 0000-0000",         1'b0, 1'b0, KIND_NONE},
        '{"ISSN 0000-006X",         1'b0, 1'b0, KIND_NONE},
        '{"ISSN 0000-006x",         1'b1, 1'b0, KIND_ISSN},
        '{"ISSN 9999-9994",         1'b0, 1'b0, KIND_NONE},
        '{"ISSN 0378-5954",         1'b0, 1'b0, KIND_NONE},
        '{"ISSN 0378-59551",        1'b1, 1'b0, KIND_ISSN},
        '{"XSSN 0378-5955",         1'b1, 1'b0, KIND_ISSN},
        '{"ISSN 0378-\2005955",     1'b1, 1'b0, KIND_ISSN},
        '{"ISBN 978-0-306-40615-7", 1'b0, 1'b0, KIND_NONE},
        '{"ISBN 979-10-90636-07-1", 1'b0, 1'b0, KIND_NONE},
        '{"ISBN 978-00005-12-12-4", 1'b0, 1'b0, KIND_NONE},
        '{"ISBN 978--0306-40615-7", 1'b0, 1'b0, KIND_NONE},
        '{"ISBN 978-0-30640615--7", 1'b0, 1'b0, KIND_NONE},
        '{"ISBN 978-123456-7-89-0", 1'b0, 1'b0, KIND_NONE},
        '{"ISBN 978-6-306-40615-7", 1'b0, 1'b0, KIND_NONE},
        '{"ISBN 977-0-306-40615-7", 1'b1, 1'b0, KIND_ISBN},
        '{"ISBN 979-99999-999-9-7", 1'b0, 1'b0, KIND_NONE},
        '{"ISBN 978-0-306-40615-7 with a long tail", 1'b1, 1'b0, KIND_ISBN}
    };

    task automatic clear_code_state;
        begin
            at_pos          = '0;
            picked_kind     = KIND_NONE;
            bad_format      = 1'b0;
            issn_sum        = '0;
            ean_sum         = '0;
            isbn_digits     = '0;
            group_no        = '0;
            group_len       = '0;
            group_one_value = '0;
        end
    endtask

    // Advances the predictor by one accepted character. On a last beat it
    // hands back the verdict on the whole code and starts over.
    task automatic predict_char(input char_t c, input logic is_last,
                                output logic done, output iicv_verdict_t verdict);
        string issn_head = "ISSN ";
        string isbn_head = "ISBN 97";
        logic  is_digit;
        int    d;
        int    w;
        int    lim;
        int    r;
        int    want;
        begin
            done = 1'b0;
            verdict.valid_res = 1'b0;
            verdict.kind = KIND_NONE;
            is_digit = (c >= CH_0) && (c <= CH_9);
            d = int'(c) - int'(CH_0);

            // The first two characters must read "IS" whatever the kind;
            // the third one picks the kind.
            if (at_pos < 2)
            begin
                if (c != issn_head[at_pos])
                begin
                    bad_format = 1'b1;
                end
            end
            else if (at_pos == 2)
            begin
                picked_kind = (c == CH_S) ? KIND_ISSN : (c == CH_B) ? KIND_ISBN : KIND_NONE;
            end

            if (at_pos >= 2 && picked_kind == KIND_ISSN)
            begin
                if (at_pos < 5)
                begin
                    bad_format |= (c != issn_head[at_pos]);
                end
                else if (at_pos == 9)
                begin
                    bad_format |= (c != CH_DASH);
                end
                else if (at_pos <= 12)
                begin
                    // Weights run 8 down to 2 over the seven digits, skipping
                    // the dash.
                    w = (at_pos < 9) ? 13 - int'(at_pos) : 14 - int'(at_pos);
                    if (!is_digit)
                    begin
                        bad_format = 1'b1;
                    end
                    else
                    begin
                        issn_sum = 4'((int'(issn_sum) + d * w) % 11);
                    end
                end
            end
            else if (at_pos >= 2 && picked_kind == KIND_ISBN)
            begin
                if (at_pos <= 6)
                begin
                    bad_format |= (c != isbn_head[at_pos]);
                end
                else if (at_pos == 7)
                begin
                    // The prefix 978 or 979 enters the EAN sum as 38 or 39, reduced mod 10.
                    if (c == CH_8)
                    begin
                        ean_sum = 4'd8;
                    end
                    else if (c == CH_9)
                    begin
                        ean_sum = 4'd9;
                    end
                    else
                    begin
                        bad_format = 1'b1;
                    end
                end
                else if (at_pos == 8)
                begin
                    bad_format |= (c != CH_DASH);
                end
                else if (at_pos <= 21)
                begin
                    if (is_digit)
                    begin
                        if (group_no == 0 && group_len < 5)
                        begin
                            group_one_value = 17'(int'(group_one_value) * 10 + d);
                        end
                        // Only the nine digits before the check digit are
                        // summed, weight 3 first.
                        if (isbn_digits < 9)
                        begin
                            ean_sum = 4'((int'(ean_sum) + d * (isbn_digits[0] ? 1 : 3)) % 10);
                        end
                        if (group_len < 15)
                        begin
                            group_len++;
                        end
                        if (isbn_digits < 15)
                        begin
                            isbn_digits++;
                        end
                    end
                    else
                    begin
                        // Any non-digit closes a group; empty groups and
                        // groups over their length are format errors.
                        lim = (group_no == 0) ? 5 : (group_no == 1) ? 7 :
                              (group_no == 2) ? 6 : 0;
                        if (group_len == 0 || group_len > lim)
                        begin
                            bad_format = 1'b1;
                        end
                        if (group_no == 0 && !(group_one_value inside {[0:5], 7, [80:94],
                            [600:649], [950:989], [9900:9980], [99900:99999]}))
                        begin
                            bad_format = 1'b1;
                        end
                        if (group_no < 4)
                        begin
                            group_no++;
                        end
                        group_len = '0;
                    end
                end
            end

            if (!is_last)
            begin
                if (at_pos < 31)
                begin
                    at_pos++;
                end
            end
            else
            begin
                done = 1'b1;
                verdict.kind = picked_kind;
                if (picked_kind == KIND_ISSN && at_pos == 13 && !bad_format)
                begin
                    r = issn_sum;
                    want = (r == 0) ? int'(CH_0) : (r == 1) ? int'(CH_X) : int'(CH_0) + 11 - r;
                    verdict.valid_res = (int'(c) == want);
                end
                else if (picked_kind == KIND_ISBN && at_pos == 21 && !bad_format &&
                         group_no == 3 && group_len == 1 && isbn_digits == 10)
                begin
                    want = (10 - int'(ean_sum)) % 10;
                    verdict.valid_res = (d == want);
                end
                clear_code_state();
            end
        end
    endtask

    // Watches both sides at the rising edge. Inputs change only at the
    // falling edge, so everything sampled here is stable.
    always @(posedge clk)
    begin : watch
        char_beat_t    b;
        logic          done;
        iicv_verdict_t predicted;
        iicv_verdict_t owed;
        iicv_verdict_t seen;
        if (rst_n && s_tvalid && s_tready)
        begin
            b = offered_beats.pop_front();
            beats_accepted++;
            predict_char(b.ch, b.last, done, predicted);
            if (done)
            begin
                verdicts_due.push_back(b.pinned ? b.pin : predicted);
            end
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            seen.valid_res = m_tdata[0];
            seen.kind = kind_t'(m_tdata[2:1]);
            if (verdicts_due.size() == 0)
            begin
                $display("%0t: verdict beat with none owed: valid_res %0b kind %0d",
                         $time, seen.valid_res, seen.kind);
                errors++;
            end
            else
            begin
                owed = verdicts_due.pop_front();
                if (seen.valid_res !== owed.valid_res)
                begin
                    $display("%0t: valid_res expected %0b, got %0b",
                             $time, owed.valid_res, seen.valid_res);
                    errors++;
                end
                if (seen.kind !== owed.kind)
                begin
                    $display("%0t: kind expected %0d, got %0d", $time, owed.kind, seen.kind);
                    errors++;
                end
            end
        end
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** issn_isbn_code_validator: FAILED **");
            $finish;
        end
    end

    // The receiver. In the pressure phase it first holds off for a long
    // stretch so that a verdict sits untaken and the input side backs up;
    // otherwise it stalls at the rate of the current phase.
    always @(negedge clk)
    begin : receiver
        int  hold_left;
        bit  hold_done;
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else if (phase == PH_PRESSURE && !hold_done)
        begin
            m_tready <= 1'b0;
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        else if (phase == PH_SNK_STALL)
        begin
            m_tready <= ($urandom_range(99) >= 73);
        end
        else if (phase == PH_BOTH)
        begin
            m_tready <= ($urandom_range(99) >= 6);
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // Offers one beat, starting at a falling edge, and returns at the
    // falling edge after it was taken. Valid stays high from one beat to the
    // next unless the sender idles.
    task automatic send_beat(input char_beat_t b);
        int idle_pct;
        int taken_before;
        begin
            idle_pct = (phase == PH_SRC_IDLE) ? 73 : (phase == PH_BOTH) ? 6 : 0;
            while (idle_pct > 0 && $urandom_range(99) < idle_pct)
            begin
                s_tvalid <= 1'b0;
                @(negedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= b.ch;
            s_tlast  <= b.last;
            offered_beats.push_back(b);
            taken_before = beats_accepted;
            while (beats_accepted == taken_before)
            begin
                @(negedge clk);
            end
        end
    endtask

    // Sends the text built in code_text, marking its last character.
    task automatic send_code(input bit pinned, input iicv_verdict_t pin);
        char_beat_t b;
        begin
            for (int i = 0; i < code_text.size(); i++)
            begin
                b.ch = code_text[i];
                b.last = (i == code_text.size() - 1);
                b.pinned = pinned && b.last;
                b.pin = pin;
                send_beat(b);
            end
        end
    endtask

    task automatic load_text(input string s);
        begin
            code_text.delete();
            for (int i = 0; i < s.len(); i++)
            begin
                code_text.push_back(s[i]);
            end
        end
    endtask

    // A well-formed ISSN with random digits and the right check character.
    task automatic build_issn;
        int d;
        int sum;
        int r;
        begin
            load_text("ISSN ");
            sum = 0;
            for (int i = 0; i < 7; i++)
            begin
                d = $urandom_range(9);
                if (i == 4)
                begin
                    code_text.push_back(CH_DASH);
                end
                code_text.push_back(8'(int'(CH_0) + d));
                sum += d * (8 - i);
            end
            r = sum % 11;
            code_text.push_back((r == 0) ? CH_0 : (r == 1) ? CH_X : 8'(int'(CH_0) + 11 - r));
        end
    endtask

    // A well-formed ISBN: random group lengths that add up to nine digits
    // before the check digit, a first group mostly from the listed ranges,
    // random separators now and then, and the right check digit.
    task automatic build_isbn;
        int  g1;
        int  g2;
        int  lo;
        int  hi;
        int  v;
        int  sum;
        int  dig[10];
        int  sep;
        bit  p979;
        begin
            p979 = 1'($urandom_range(1));
            load_text(p979 ? "ISBN 979-" : "ISBN 978-");
            g1 = $urandom_range(5, 1);
            lo = (3 - g1 > 1) ? 3 - g1 : 1;
            hi = (8 - g1 < 7) ? 8 - g1 : 7;
            g2 = $urandom_range(hi, lo);
            case (g1)
                1:
                begin
                    v = $urandom_range(6);
                    if (v == 6)
                    begin
                        v = 7;
                    end
                end
                2:       v = $urandom_range(94, 80);
                3:       v = $urandom_range(1) ? $urandom_range(649, 600) : $urandom_range(989, 950);
                4:       v = $urandom_range(9980, 9900);
                default: v = $urandom_range(99999, 99900);
            endcase
            if ($urandom_range(9) == 0)
            begin
                v = $urandom_range(99999) % (10 ** g1);
            end
            for (int k = 0; k < g1; k++)
            begin
                dig[k] = (v / (10 ** (g1 - 1 - k))) % 10;
            end
            for (int k = g1; k < 9; k++)
            begin
                dig[k] = $urandom_range(9);
            end
            sum = p979 ? 39 : 38;
            for (int k = 0; k < 9; k++)
            begin
                sum += dig[k] * ((k % 2 == 0) ? 3 : 1);
            end
            dig[9] = (10 - sum % 10) % 10;
            for (int k = 0; k < 10; k++)
            begin
                if (k == g1 || k == g1 + g2 || k == 9)
                begin
                    sep = CH_DASH;
                    if ($urandom_range(99) < 15)
                    begin
                        do
                        begin
                            sep = $urandom_range(255);
                        end
                        while (sep >= CH_0 && sep <= CH_9);
                    end
                    code_text.push_back(8'(sep));
                end
                code_text.push_back(8'(int'(CH_0) + dig[k]));
            end
        end
    endtask

    // One random code: mostly well-formed ISSN and ISBN texts, a quarter of
    // them broken by one edit, and the rest random bytes of random length.
    task automatic build_random_code;
        int pick;
        int at;
        int len;
        begin
            pick = $urandom_range(99);
            if (pick < 40)
            begin
                build_issn();
            end
            else if (pick < 80)
            begin
                build_isbn();
            end
            else
            begin
                len = $urandom_range(36, 1);
                if ($urandom_range(1))
                begin
                    load_text("IS");
                end
                else
                begin
                    code_text.delete();
                end
                while (code_text.size() < len)
                begin
                    code_text.push_back(8'($urandom_range(255)));
                end
            end
            if (pick < 80 && $urandom_range(3) == 0)
            begin
                at = $urandom_range(code_text.size() - 1);
                case ($urandom_range(3))
                    0: code_text[at] = 8'($urandom_range(255));
                    1: code_text.delete(at);
                    2: code_text.insert(at, 8'($urandom_range(255)));
                    default: code_text[code_text.size() - 1] = 8'(int'(CH_0) + $urandom_range(9));
                endcase
            end
        end
    endtask

    task automatic run_phase(input phase_t ph, input int beat_count);
        int sent;
        iicv_verdict_t none;
        begin
            phase = ph;
            sent = 0;
            none = '0;
            while (sent < beat_count)
            begin
                build_random_code();
                send_code(1'b0, none);
                sent += code_text.size();
            end
        end
    endtask

    initial
    begin : stimulus
        iicv_verdict_t pin;
        clear_code_state();
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed codes first, with no idling on either side.
        foreach (directed_codes[i])
        begin
            load_text(directed_codes[i].text);
            pin.valid_res = directed_codes[i].want_valid;
            pin.kind = directed_codes[i].want_kind;
            send_code(directed_codes[i].pinned, pin);
        end

        run_phase(PH_STEADY, 300);
        run_phase(PH_SRC_IDLE, 300);
        run_phase(PH_SNK_STALL, 350);
        run_phase(PH_PRESSURE, 250);
        run_phase(PH_BOTH, 400);

        s_tvalid <= 1'b0;
        while (verdicts_due.size() != 0)
        begin
            @(negedge clk);
        end
        // A verdict that was never owed would still show up during this wait.
        repeat (8) @(negedge clk);
        if (errors == 0)
        begin
            $display("** issn_isbn_code_validator: PASSED **");
        end
        else
        begin
            $display("** issn_isbn_code_validator: FAILED **");
        end
        $finish;
    end

endmodule
